[sv/fvn_pkg.sv]
package fvn_pkg;

    // Fixed constants of the splitmix64 finalizer.
    localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2  = 64'h94d049bb133111eb;
    // Seed step from one octave to the next.
    localparam logic [63:0] OCT_SEED_STEP = 64'h0000_0000_9e37_79b9;

    // Q8.24 one, used as the first octave amplitude.
    localparam logic [31:0] Q24_ONE = 32'h0100_0000;

    // Weighted sum in Q16.48 and amplitude sum in Q16.24.
    localparam int SUM_W  = 64;
    localparam int NORM_W = 40;
    // Bits of the normalized result (Q0.24).
    localparam int NRM_W  = 24;

    typedef enum logic [2:0] {
        REG_BASE_FREQ = 3'd0,
        REG_LACUNARITY = 3'd1,
        REG_GAIN = 3'd2,
        REG_OUT_SCALE = 3'd3,
        REG_OUT_BIAS = 3'd4,
        REG_OCTAVES = 3'd5,
        REG_ROW_WIDTH = 3'd6,
        REG_SEED = 3'd7
    } cfg_idx_t;

    // Settings every octave slice needs.
    typedef struct packed {
        logic [31:0] lacunarity;
        logic [31:0] gain;
        logic [4:0]  octave_count;
        logic [63:0] noise_seed;
    } oct_cfg_t;

endpackage

[sv/fvn_div.sv]
module fvn_div #(
    parameter int QW = 24,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_bits,
    input  logic [DW-1:0] in_divisor,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem
);

    // One restoring step per stage; quotient bits shift in where dividend bits leave.
    logic [QW-1:0] vld_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] bits_reg [QW];
    logic [DW-1:0] div_reg [QW];

    logic [DW-1:0] rem_src [QW];
    logic [QW-1:0] bits_src [QW];
    logic [DW-1:0] div_src [QW];
    logic          vld_src [QW];

    logic [DW-1:0] rem_next [QW];
    logic [QW-1:0] bits_next [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW:0] trial;
        logic        ge;

        if (i == 0) begin : g_first
            assign rem_src[i]  = in_rem;
            assign bits_src[i] = in_bits;
            assign div_src[i]  = in_divisor;
            assign vld_src[i]  = in_valid;
        end
        else begin : g_rest
            assign rem_src[i]  = rem_reg[i-1];
            assign bits_src[i] = bits_reg[i-1];
            assign div_src[i]  = div_reg[i-1];
            assign vld_src[i]  = vld_reg[i-1];
        end

        assign trial = {rem_src[i], bits_src[i][QW-1]};
        assign ge    = trial >= {1'b0, div_src[i]};

        assign rem_next[i]  = ge ? DW'(trial - {1'b0, div_src[i]}) : trial[DW-1:0];
        assign bits_next[i] = {bits_src[i][QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                vld_reg[i] <= vld_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                bits_reg[i] <= bits_next[i];
                div_reg[i]  <= div_src[i];
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = bits_reg[QW-1];
    assign rem       = rem_reg[QW-1];

endmodule

[sv/fvn_octave.sv]
module fvn_octave import fvn_pkg::*; #(
    parameter int INDEX_BITS    = 24,
    parameter int FRACTION_BITS = 24,
    parameter int OCT           = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  oct_cfg_t              cfg,
    input  logic                  in_valid,
    input  logic [INDEX_BITS-1:0] in_px,
    input  logic [INDEX_BITS-1:0] in_py,
    input  logic [31:0]           in_freq,
    input  logic [31:0]           in_amp,
    input  logic [SUM_W-1:0]      in_sum,
    input  logic [NORM_W-1:0]     in_norm,
    output logic                  out_valid,
    output logic [INDEX_BITS-1:0] out_px,
    output logic [INDEX_BITS-1:0] out_py,
    output logic [31:0]           out_freq,
    output logic [31:0]           out_amp,
    output logic [SUM_W-1:0]      out_sum,
    output logic [NORM_W-1:0]     out_norm
);

    localparam int F   = FRACTION_BITS;
    localparam int PW  = INDEX_BITS + 32;
    localparam int LAT = 10;
    localparam logic [63:0] SEED_OFS = 64'(OCT) * OCT_SEED_STEP;
    localparam logic [F:0]  ONE_F = (F+1)'(1) << F;

    logic [LAT-1:0]        vld_reg;
    logic [INDEX_BITS-1:0] px_reg [LAT];
    logic [INDEX_BITS-1:0] py_reg [LAT];
    logic [31:0]           amp_reg [LAT-1];
    logic [SUM_W-1:0]      sum_reg [LAT-1];
    logic [NORM_W-1:0]     norm_reg [LAT-1];
    logic [31:0]           frq_nx_reg [LAT-1];
    logic [31:0]           amp_nx_reg [LAT-1];

    // Stage 1: coordinate and update products.
    logic [PW-1:0] cxp_reg, cyp_reg;
    logic [63:0]   fpr_reg, apr_reg, seed_reg;
    // Stage 2: keys after the first xor-shift, raw fractions.
    logic [63:0]   h1_reg [4];
    logic [F-1:0]  tx_reg, ty_reg;
    // Stage 3: first finalizer product in 32-bit pieces, fade square.
    logic [63:0]   pa_reg [4];
    logic [31:0]   pb_reg [4];
    logic [31:0]   pc_reg [4];
    logic [2*F-1:0] sqx_reg, sqy_reg;
    logic [F+1:0]  kx_reg, ky_reg;
    // Stage 4.
    logic [63:0]   h2_reg [4];
    logic [2*F+1:0] fpx_reg, fpy_reg;
    // Stage 5.
    logic [63:0]   qa_reg [4];
    logic [31:0]   qb_reg [4];
    logic [31:0]   qc_reg [4];
    logic [F:0]    sx_reg, sy_reg;
    // Stage 6.
    logic [F-1:0]  val_reg [4];
    logic [F:0]    sx6_reg, sy6_reg;
    // Stages 7 to 10.
    logic [F-1:0]  a_reg, b_reg;
    logic [F:0]    sy7_reg;
    logic [23:0]   n_reg;
    logic [55:0]   an_reg;
    logic [SUM_W-1:0]  sum_out_reg;
    logic [NORM_W-1:0] norm_out_reg;

    logic [63:0] cx64, cy64;
    logic [47:0] cx_sat, cy_sat;
    logic [31:0] ix, iy, ix1, iy1;
    logic [63:0] h1_next [4];
    logic [63:0] h2_next [4];
    logic [F-1:0] val_next [4];
    logic [31:0] frq_sat, amp_sat;
    logic [2*F:0] bl_a, bl_b, bl_n;
    logic        active;

    always_comb
    begin
        logic [31:0] kx, ky;
        logic [63:0] v, m;
        cx64   = 64'(cxp_reg);
        cy64   = 64'(cyp_reg);
        cx_sat = (|cx64[63:48]) ? 48'hFFFF_FFFF_FFFF : cx64[47:0];
        cy_sat = (|cy64[63:48]) ? 48'hFFFF_FFFF_FFFF : cy64[47:0];
        ix  = {8'd0, cx_sat[47:24]};
        iy  = {8'd0, cy_sat[47:24]};
        ix1 = ix + 32'd1;
        iy1 = iy + 32'd1;
        for (int c = 0; c < 4; c++)
        begin
            kx = ((c & 1) != 0) ? ix1 : ix;
            ky = ((c & 2) != 0) ? iy1 : iy;
            v  = ({ky, kx} ^ seed_reg) + MIX_ADD;
            h1_next[c] = v ^ (v >> 30);
            m  = pa_reg[c] + {pb_reg[c] + pc_reg[c], 32'd0};
            h2_next[c] = m ^ (m >> 27);
            m  = qa_reg[c] + {qb_reg[c] + qc_reg[c], 32'd0};
            m  = m ^ (m >> 31);
            val_next[c] = m[63 -: F];
        end
        frq_sat = (|fpr_reg[63:56]) ? 32'hFFFF_FFFF : fpr_reg[55:24];
        amp_sat = (|apr_reg[63:56]) ? 32'hFFFF_FFFF : apr_reg[55:24];
        bl_a = (2*F+1)'(val_reg[0] * (ONE_F - sx6_reg)) + (2*F+1)'(val_reg[1] * sx6_reg);
        bl_b = (2*F+1)'(val_reg[2] * (ONE_F - sx6_reg)) + (2*F+1)'(val_reg[3] * sx6_reg);
        bl_n = (2*F+1)'(a_reg * (ONE_F - sy7_reg)) + (2*F+1)'(b_reg * sy7_reg);
        active = (OCT == 0) || (OCT < int'(cfg.octave_count));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[0]   <= in_px;
            py_reg[0]   <= in_py;
            amp_reg[0]  <= in_amp;
            sum_reg[0]  <= in_sum;
            norm_reg[0] <= in_norm;
            for (int k = 1; k < LAT; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
            end
            for (int k = 1; k < LAT-1; k++)
            begin
                amp_reg[k]    <= amp_reg[k-1];
                sum_reg[k]    <= sum_reg[k-1];
                norm_reg[k]   <= norm_reg[k-1];
                frq_nx_reg[k] <= frq_nx_reg[k-1];
                amp_nx_reg[k] <= amp_nx_reg[k-1];
            end
            frq_nx_reg[0] <= frq_sat;
            amp_nx_reg[0] <= amp_sat;

            cxp_reg  <= PW'(in_px * in_freq);
            cyp_reg  <= PW'(in_py * in_freq);
            fpr_reg  <= 64'(in_freq) * 64'(cfg.lacunarity);
            apr_reg  <= 64'(in_amp) * 64'(cfg.gain);
            seed_reg <= cfg.noise_seed + SEED_OFS;

            tx_reg <= cx_sat[23 -: F];
            ty_reg <= cy_sat[23 -: F];
            for (int c = 0; c < 4; c++)
            begin
                h1_reg[c] <= h1_next[c];
                pa_reg[c] <= 64'(h1_reg[c][31:0]) * 64'(MIX_M1[31:0]);
                pb_reg[c] <= 32'(h1_reg[c][63:32] * MIX_M1[31:0]);
                pc_reg[c] <= 32'(h1_reg[c][31:0] * MIX_M1[63:32]);
                h2_reg[c] <= h2_next[c];
                qa_reg[c] <= 64'(h2_reg[c][31:0]) * 64'(MIX_M2[31:0]);
                qb_reg[c] <= 32'(h2_reg[c][63:32] * MIX_M2[31:0]);
                qc_reg[c] <= 32'(h2_reg[c][31:0] * MIX_M2[63:32]);
                val_reg[c] <= val_next[c];
            end

            // Smoothstep: t2 = t*t >> F, s = t2 * (3 - 2t) >> F.
            sqx_reg <= (2*F)'(tx_reg * tx_reg);
            sqy_reg <= (2*F)'(ty_reg * ty_reg);
            kx_reg  <= ((F+2)'(3) << F) - {1'b0, tx_reg, 1'b0};
            ky_reg  <= ((F+2)'(3) << F) - {1'b0, ty_reg, 1'b0};
            fpx_reg <= (2*F+2)'(sqx_reg[2*F-1:F] * kx_reg);
            fpy_reg <= (2*F+2)'(sqy_reg[2*F-1:F] * ky_reg);
            sx_reg  <= fpx_reg[2*F:F];
            sy_reg  <= fpy_reg[2*F:F];
            sx6_reg <= sx_reg;
            sy6_reg <= sy_reg;
            sy7_reg <= sy6_reg;

            a_reg  <= bl_a[2*F-1:F];
            b_reg  <= bl_b[2*F-1:F];
            n_reg  <= 24'(bl_n[2*F-1:F]) << (24 - F);
            an_reg <= 56'(amp_reg[LAT-3]) * 56'(n_reg);

            sum_out_reg  <= active ? sum_reg[LAT-2] + SUM_W'(an_reg) : sum_reg[LAT-2];
            norm_out_reg <= active ? norm_reg[LAT-2] + NORM_W'(amp_reg[LAT-2])
                                   : norm_reg[LAT-2];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_px    = px_reg[LAT-1];
    assign out_py    = py_reg[LAT-1];
    assign out_freq  = frq_nx_reg[LAT-2];
    assign out_amp   = amp_nx_reg[LAT-2];
    assign out_sum   = sum_out_reg;
    assign out_norm  = norm_out_reg;

endmodule

[sv/fractal_value_noise.sv]
// Channel   Signals                                 Carries
// input     in_valid, in_ready, element_index       one raster position per item
// output    out_valid, out_ready, noise_value       one Q8.24 noise sample per item
// config    cfg_write, cfg_index, cfg_data          register writes, no wait
//
// One item enters per cycle while the output is not stalled. The pipe is built from the
// bit-per-stage row split, ten stages per octave slice, the bit-per-stage normalizing
// divide and the scale and output registers. Reset clears all valid bits and loads the
// register defaults. A stall on the output freezes the whole pipe; the input is taken
// whenever the output register is empty or being drained.
module fractal_value_noise import fvn_pkg::*; #(
    parameter int MAX_OCTAVES   = 16,
    parameter int INDEX_BITS    = 24,
    parameter int FRACTION_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] element_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    noise_value,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    // Configuration registers. The user must change them only while no item is in
    // flight (the block does not enforce it), so the pipeline reads them directly.
    logic [31:0] base_freq_reg, lacunarity_reg, gain_reg;
    logic [31:0] out_scale_reg, out_bias_reg;
    logic [4:0]  octave_count_reg;
    logic [15:0] row_width_reg;
    logic [63:0] noise_seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_freq_reg    <= 32'd167772;
            lacunarity_reg   <= 32'h0200_0000;
            gain_reg         <= 32'h0080_0000;
            out_scale_reg    <= Q24_ONE;
            out_bias_reg     <= 32'd0;
            octave_count_reg <= 5'd4;
            row_width_reg    <= 16'd1;
            noise_seed_reg   <= 64'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BASE_FREQ:  base_freq_reg    <= cfg_data[31:0];
                REG_LACUNARITY: lacunarity_reg   <= cfg_data[31:0];
                REG_GAIN:       gain_reg         <= cfg_data[31:0];
                REG_OUT_SCALE:  out_scale_reg    <= cfg_data[31:0];
                REG_OUT_BIAS:   out_bias_reg     <= cfg_data[31:0];
                REG_OCTAVES:    octave_count_reg <= cfg_data[4:0];
                REG_ROW_WIDTH:  row_width_reg    <= cfg_data[15:0];
                REG_SEED:       noise_seed_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // The whole pipe advances together whenever the output register can move.
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Split the index: x is the remainder and y the quotient by the row width.
    // A zero width behaves as one.
    logic [15:0]           row_w;
    logic                  split_valid;
    logic [INDEX_BITS-1:0] split_y;
    logic [15:0]           split_x;

    assign row_w = (row_width_reg == 16'd0) ? 16'd1 : row_width_reg;

    fvn_div #(
        .QW (INDEX_BITS),
        .DW (16)
    ) u_split (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .in_rem     (16'd0),
        .in_bits    (element_index),
        .in_divisor (row_w),
        .out_valid  (split_valid),
        .quo        (split_y),
        .rem        (split_x)
    );

    // Octave slices. Each one carries the coordinates forward, adds its weighted
    // sample to the running sums and hands the next frequency and amplitude on.
    oct_cfg_t oct_cfg;
    assign oct_cfg = '{lacunarity: lacunarity_reg, gain: gain_reg,
                       octave_count: octave_count_reg, noise_seed: noise_seed_reg};

    logic                  o_valid [MAX_OCTAVES+1];
    logic [INDEX_BITS-1:0] o_px    [MAX_OCTAVES+1];
    logic [INDEX_BITS-1:0] o_py    [MAX_OCTAVES+1];
    logic [31:0]           o_freq  [MAX_OCTAVES+1];
    logic [31:0]           o_amp   [MAX_OCTAVES+1];
    logic [SUM_W-1:0]      o_sum   [MAX_OCTAVES+1];
    logic [NORM_W-1:0]     o_norm  [MAX_OCTAVES+1];

    // The remainder is never larger than the index itself, so it fits.
    assign o_valid[0] = split_valid;
    assign o_px[0]    = INDEX_BITS'(split_x);
    assign o_py[0]    = split_y;
    assign o_freq[0]  = base_freq_reg;
    assign o_amp[0]   = Q24_ONE;
    assign o_sum[0]   = '0;
    assign o_norm[0]  = '0;

    for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
        fvn_octave #(
            .INDEX_BITS    (INDEX_BITS),
            .FRACTION_BITS (FRACTION_BITS),
            .OCT           (o)
        ) u_oct (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .cfg       (oct_cfg),
            .in_valid  (o_valid[o]),
            .in_px     (o_px[o]),
            .in_py     (o_py[o]),
            .in_freq   (o_freq[o]),
            .in_amp    (o_amp[o]),
            .in_sum    (o_sum[o]),
            .in_norm   (o_norm[o]),
            .out_valid (o_valid[o+1]),
            .out_px    (o_px[o+1]),
            .out_py    (o_py[o+1]),
            .out_freq  (o_freq[o+1]),
            .out_amp   (o_amp[o+1]),
            .out_sum   (o_sum[o+1]),
            .out_norm  (o_norm[o+1])
        );
    end

    // Normalize. The quotient is a weighted mean of values below one, so it
    // fits in 24 bits and the upper part of the sum starts out as the
    // partial remainder.
    logic              nrm_valid;
    logic [NRM_W-1:0]  nrm;
    logic [NORM_W-1:0] nrm_rem;

    fvn_div #(
        .QW (NRM_W),
        .DW (NORM_W)
    ) u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (o_valid[MAX_OCTAVES]),
        .in_rem     (o_sum[MAX_OCTAVES][SUM_W-1:NRM_W]),
        .in_bits    (o_sum[MAX_OCTAVES][NRM_W-1:0]),
        .in_divisor (o_norm[MAX_OCTAVES]),
        .out_valid  (nrm_valid),
        .quo        (nrm),
        .rem        (nrm_rem)
    );

    // Final scale and offset, then saturation to the signed 32-bit range.
    logic signed [56:0] prod_reg;
    logic               prod_valid_reg;
    logic signed [31:0] out_reg;
    logic signed [56:0] prod_next;
    logic signed [55:0] bias_sh;
    logic signed [57:0] total;
    logic signed [33:0] shifted;
    logic signed [31:0] out_next;

    always_comb
    begin
        prod_next = $signed(out_scale_reg) * $signed({1'b0, nrm});
        bias_sh   = $signed({out_bias_reg, 24'd0});
        total     = 58'(prod_reg) + 58'(bias_sh);
        shifted   = total[57:24];
        if (shifted[33:31] == 3'b000 || shifted[33:31] == 3'b111)
        begin
            out_next = shifted[31:0];
        end
        else if (shifted[33])
        begin
            out_next = 32'sh8000_0000;
        end
        else
        begin
            out_next = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= nrm_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // The leftover remainder of the normalizing divide is not needed; only
    // its quotient continues.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (nrm_rem == '0 || nrm_rem != '0) ? prod_next : prod_next;
            out_reg  <= out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_reg;

endmodule
